FILE: design/osgs_pkg.sv
// shared types, opcodes and form helpers for the oriented square grid store
package osgs_pkg;

  localparam int unsigned DEF_MAX_SIDE   = 64;
  localparam int unsigned DEF_CELL_WIDTH = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned DATA_W  = 32;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_READ         = 3'd0,
    OP_WRITE        = 3'd1,
    OP_ROT_LEFT     = 3'd2,
    OP_ROT_RIGHT    = 3'd3,
    OP_SWAP_AXES    = 3'd4,
    OP_REV_ROWS     = 3'd5,
    OP_REV_COLS     = 3'd6,
    OP_RESET_ORIENT = 3'd7
  } opcode_t;

  // one linear form: coefficients are -1, 0 or +1, bias set means size - 1
  typedef struct packed {
    logic signed [1:0] cr;
    logic signed [1:0] cc;
    logic              bias;
  } form_t;

  localparam form_t ROW_IDENT = '{cr: 2'sd1, cc: 2'sd0, bias: 1'b0};
  localparam form_t COL_IDENT = '{cr: 2'sd0, cc: 2'sd1, bias: 1'b0};

  // mapped access handed from the orientation unit to the top level
  typedef struct packed {
    logic              oor;
    logic [SIZE_W-1:0] pr;
    logic [SIZE_W-1:0] pc;
  } map_t;

  function automatic form_t form_flip(input form_t f);
    form_t r;
    r.cr   = -f.cr;
    r.cc   = -f.cc;
    r.bias = ~f.bias;
    return r;
  endfunction

  function automatic logic signed [9:0] coef_term(input logic signed [1:0] k,
                                                   input logic [COORD_W-1:0] x);
    logic signed [9:0] xs;
    xs = $signed({4'b0, x});
    case (k)
      2'sd1:   coef_term = xs;
      -2'sd1:  coef_term = -xs;
      default: coef_term = 10'sd0;
    endcase
  endfunction

  // evaluate a form and clamp into 0 .. n-1
  function automatic logic [SIZE_W-1:0] form_eval(input form_t f,
                                                  input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] n);
    logic signed [9:0] nm1;
    logic signed [9:0] v;
    nm1 = $signed({3'b0, n}) - 10'sd1;
    v   = coef_term(f.cr, r) + coef_term(f.cc, c) + (f.bias ? nm1 : 10'sd0);
    if (v < 10'sd0) begin
      v = 10'sd0;
    end
    if (v > nm1) begin
      v = nm1;
    end
    return v[SIZE_W-1:0];
  endfunction

endpackage

FILE: design/osgs_cmd_if.sv
// command channel: one operation per beat
interface osgs_cmd_if import osgs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [DATA_W-1:0]  write_value;

  modport source (output valid, opcode, row, col, write_value, input ready);
  modport sink   (input valid, opcode, row, col, write_value, output ready);
endinterface

FILE: design/osgs_rsp_if.sv
// response channel: one result per command beat
interface osgs_rsp_if import osgs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic              out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

FILE: design/osgs_cfg_if.sv
// configuration write channel for the grid size register
interface osgs_cfg_if import osgs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink   (input valid, grid_size, output ready);
endinterface

FILE: design/osgs_ram.sv
// generic single port ram with registered read
module osgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/osgs_orient.sv
// orientation forms, range check and logical to physical coordinate map
module osgs_orient import osgs_pkg::*; #(
  parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SIZE_W-1:0]  grid_size,
  input  logic               accept,
  input  opcode_t            opcode,
  input  logic [COORD_W-1:0] row,
  input  logic [COORD_W-1:0] col,
  output map_t               map
);

  localparam int unsigned SIDE_CAP = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

  form_t row_form, row_form_next;
  form_t col_form, col_form_next;
  logic [SIZE_W-1:0] n;

  assign n = (grid_size > SIZE_W'(SIDE_CAP)) ? SIZE_W'(SIDE_CAP) : grid_size;

  always_comb begin
    map.oor = ({1'b0, row} >= n) || ({1'b0, col} >= n);
    map.pr  = form_eval(row_form, row, col, n);
    map.pc  = form_eval(col_form, row, col, n);
  end

  always_comb begin
    row_form_next = row_form;
    col_form_next = col_form;
    if (accept) begin
      case (opcode)
        OP_ROT_LEFT: begin
          row_form_next = col_form;
          col_form_next = form_flip(row_form);
        end
        OP_ROT_RIGHT: begin
          row_form_next = form_flip(col_form);
          col_form_next = row_form;
        end
        OP_SWAP_AXES: begin
          row_form_next = '{cr: row_form.cc, cc: row_form.cr, bias: row_form.bias};
          col_form_next = '{cr: col_form.cc, cc: col_form.cr, bias: col_form.bias};
        end
        OP_REV_ROWS:     row_form_next = form_flip(row_form);
        OP_REV_COLS:     col_form_next = form_flip(col_form);
        OP_RESET_ORIENT: begin
          row_form_next = ROW_IDENT;
          col_form_next = COL_IDENT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_form <= ROW_IDENT;
      col_form <= COL_IDENT;
    end else begin
      row_form <= row_form_next;
      col_form <= col_form_next;
    end
  end

endmodule

FILE: design/oriented_square_grid_store_unit.sv
// top level of the oriented square grid store
//
// A MAX_SIDE by MAX_SIDE cell store seen through one of the eight rotations
// and reflections of the square. Commands arrive on cmd, one per beat:
// read, write, or one of six orientation updates that change only the
// mapping and never move data. Every command gives exactly one beat on rsp,
// in order: read_value carries the cell on an in-range read and zero
// otherwise; out_of_range flags a read or write whose row or col is not
// below the size in use. cfg writes the grid size; it is taken at any time
// and is meant to change only while the block is idle.
// A command beat passes through the registered cell memory read and then
// the response register before its response beat. Up to one command per
// cycle is accepted while rsp is not stalled; the single memory port is used
// at most once per command. When rsp stalls, one result waits in the response
// register and one more in the memory read stage, after which cmd.ready drops.
// Reset sets the orientation to identity and the grid size to 64 and empties
// both stages; cell contents are left as they are and read undefined until
// written.
module oriented_square_grid_store_unit import osgs_pkg::*; #(
  parameter int unsigned MAX_SIDE   = DEF_MAX_SIDE,
  parameter int unsigned CELL_WIDTH = DEF_CELL_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  osgs_cfg_if.sink    cfg,
  osgs_cmd_if.sink    cmd,
  osgs_rsp_if.source  rsp
);

  localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [SIZE_W-1:0]     grid_size;
  map_t                  map;
  opcode_t               op;
  logic                  cmd_acc;
  logic [ADDR_W-1:0]     addr;
  logic                  ram_we;
  logic                  ram_re;
  logic [CELL_WIDTH-1:0] ram_rdata;

  // memory read stage
  logic s1_valid, s1_rd, s1_oor;
  logic s1_adv;

  assign op      = opcode_t'(cmd.opcode);
  assign s1_adv  = s1_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign cmd_acc = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RESET;
    end else if (cfg.valid) begin
      grid_size <= cfg.grid_size;
    end
  end

  osgs_orient #(.MAX_SIDE(MAX_SIDE)) u_orient (
    .clk       (clk),
    .rst       (rst),
    .grid_size (grid_size),
    .accept    (cmd_acc),
    .opcode    (op),
    .row       (cmd.row),
    .col       (cmd.col),
    .map       (map)
  );

  assign addr   = ADDR_W'(ADDR_W'(map.pr) * ADDR_W'(MAX_SIDE) + ADDR_W'(map.pc));
  assign ram_we = cmd_acc && (op == OP_WRITE) && !map.oor;
  assign ram_re = cmd_acc && (op == OP_READ) && !map.oor;

  osgs_ram #(.WIDTH(CELL_WIDTH), .DEPTH(DEPTH)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr),
    .wdata (CELL_WIDTH'(cmd.write_value)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      s1_rd  <= ram_re;
      s1_oor <= ((op == OP_READ) || (op == OP_WRITE)) && map.oor;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.read_value   <= s1_rd ? DATA_W'(ram_rdata) : '0;
      rsp.out_of_range <= s1_oor;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !rsp.valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |-> rsp.read_value == '0)
    else $error("out of range result carries data");

  a_non_read_no_data: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && (op != OP_READ) |=> s1_valid && !s1_rd)
    else $error("non-read command marked as read");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp.valid && !rsp.ready |=> s1_valid && $stable(s1_rd) && $stable(s1_oor))
    else $error("stalled read stage lost its result");

endmodule
